### hw/rtl/friedman_key_length_estimator_macros.svh
// Assertion macros shared by the key length estimator RTL.
// No dependencies; included by the top level only.
`ifndef FRIEDMAN_KEY_LENGTH_ESTIMATOR_MACROS_SVH
`define FRIEDMAN_KEY_LENGTH_ESTIMATOR_MACROS_SVH

// Same-cycle implication, checked out of reset
`define FKE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define FKE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/fke_pkg.sv
// Shared constants and controller/datapath interface types for the estimator.
// No dependencies; used by fke_ctrl, fke_dp and the top level.
package fke_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int LETTERS     = 26;
    localparam int IDX_W       = 5;
    localparam int CHAR_W      = 8;
    localparam int OUT_CNT_W   = 16;
    localparam int EST_W       = 21;
    localparam int EST_LIMIT   = 1000000;

    localparam int CHAR_A      = 65;
    localparam int CHAR_Z      = 90;

    // Fixed-point scale factors of the Friedman estimate
    localparam int SCALE_S     = 10000;
    localparam int SCALE_P     = 385;
    localparam int SCALE_NUM   = 57000;

    // Arithmetic widths
    localparam int P_W         = 2 * COUNT_WIDTH;   // n(n-1)
    localparam int S_W         = P_W + 5;           // sum over 26 letters
    localparam int A_W         = S_W + 14;          // 10000 * S
    localparam int DIV_W       = A_W + 1;           // dividend and divisor
    localparam int REM_W       = DIV_W + 1;
    localparam int STEP_W      = $clog2(DIV_W);

    localparam logic KIND_COUNT = 1'b0;
    localparam logic KIND_EST   = 1'b1;

    typedef struct packed {
        logic             count_en;
        logic             rpt_load;
        logic [IDX_W-1:0] rpt_idx;
        logic             calc_pn;
        logic             calc_a;
        logic             calc_b;
        logic             calc_c;
        logic             calc_cmp;
        logic             calc_prep;
        logic             div_step;
        logic             est_load;
        logic             hist_clear;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic undef;
    } t_sts;

endpackage

### hw/rtl/friedman_key_length_estimator.sv
// Friedman key length estimator: top level joining controller and datapath.
// Depends on fke_pkg, fke_ctrl, fke_dp and the assertion macro header.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one ciphertext byte per
//   request; bytes A..Z are counted in a 26-entry saturating histogram.
//   While counting, one byte is taken every cycle.
//   A request with i_last high is counted, then starts a report: 26 letter
//   count results (A..Z, one per cycle when the receiver is ready), then one
//   estimate result with o_last_result high. The estimate runs the arithmetic
//   steps PN, A, B, C, CMP and PREP, then a restoring divider (skipped when
//   undefined); input is taken again on the cycle after the estimate loads.
//   A single output register separates the sides: a held result stalls the
//   report sequencer, and no input is taken while the estimate waits.
//   Reset (synchronous, active low) clears the histogram, total and output
//   valid; the histogram is also cleared when each report completes.
`include "friedman_key_length_estimator_macros.svh"

module friedman_key_length_estimator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [fke_pkg::CHAR_W-1:0]           i_char_code,
    input  logic                                 i_last,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_kind,
    output logic [fke_pkg::IDX_W-1:0]            o_letter_index,
    output logic [fke_pkg::OUT_CNT_W-1:0]        o_letter_count,
    output logic signed [fke_pkg::EST_W-1:0]     o_estimate_hundredths,
    output logic                                 o_undefined,
    output logic                                 o_last_result
);
    import fke_pkg::*;

    t_cmd cmd;
    t_sts sts;

    fke_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_last),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    fke_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .i_char_code           (i_char_code),
        .i_out_ready           (i_out_ready),
        .o_sts                 (sts),
        .o_out_valid           (o_out_valid),
        .o_kind                (o_kind),
        .o_letter_index        (o_letter_index),
        .o_letter_count        (o_letter_count),
        .o_estimate_hundredths (o_estimate_hundredths),
        .o_undefined           (o_undefined),
        .o_last_result         (o_last_result)
    );

    // Checks
    `FKE_ASSERT_NOW(a_load_free, i_clk, i_rst_n,
        cmd.rpt_load || cmd.est_load, sts.out_free, "result loaded over a held result")
    `FKE_ASSERT_NOW(a_no_input_in_report, i_clk, i_rst_n,
        cmd.rpt_load || cmd.div_step, !o_in_ready, "input taken during report")
    `FKE_ASSERT_NEXT(a_est_then_count, i_clk, i_rst_n,
        cmd.est_load, o_in_ready && o_out_valid && o_last_result,
        "estimate not presented or input not resumed")

endmodule

### hw/rtl/fke_ctrl.sv
// Sequencer for the estimator: counting, report, arithmetic steps, division.
// Depends on fke_pkg; drives fke_dp through t_cmd.
module fke_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last,
    input  fke_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output fke_pkg::t_cmd o_cmd
);
    import fke_pkg::*;

    typedef enum logic [3:0] {
        ST_COUNT, ST_REPORT, ST_PN, ST_A, ST_B, ST_C,
        ST_CMP, ST_PREP, ST_DIV, ST_EST
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [STEP_W-1:0] r_step, n_step;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.rpt_idx = r_idx;
        case (r_state)
            ST_COUNT: begin
                o_in_ready     = 1'b1;
                o_cmd.count_en = i_in_valid;
                if (i_in_valid && i_last) begin
                    n_state = ST_REPORT;
                    n_idx   = '0;
                end
            end
            ST_REPORT: begin
                if (i_sts.out_free) begin
                    o_cmd.rpt_load = 1'b1;
                    if (r_idx == IDX_W'(LETTERS - 1)) begin
                        n_idx   = '0;
                        n_state = ST_PN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_PN: begin
                o_cmd.calc_pn = 1'b1;
                n_state       = ST_A;
            end
            ST_A: begin
                o_cmd.calc_a = 1'b1;
                n_state      = ST_B;
            end
            ST_B: begin
                o_cmd.calc_b = 1'b1;
                n_state      = ST_C;
            end
            ST_C: begin
                o_cmd.calc_c = 1'b1;
                n_state      = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.calc_cmp = 1'b1;
                n_state        = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.calc_prep = 1'b1;
                n_step          = '0;
                n_state         = i_sts.undef ? ST_EST : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_W'(DIV_W - 1)) begin
                    n_state = ST_EST;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_EST: begin
                if (i_sts.out_free) begin
                    o_cmd.est_load   = 1'b1;
                    o_cmd.hist_clear = 1'b1;
                    n_state          = ST_COUNT;
                end
            end
            default: begin
                n_state = ST_COUNT;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COUNT;
            r_idx   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_step  <= n_step;
        end
    end

endmodule

### hw/rtl/fke_dp.sv
// Datapath: letter histogram, sum of n(n-1), estimate arithmetic, divider,
// output register. Depends on fke_pkg; controlled by fke_ctrl via t_cmd.
module fke_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fke_pkg::t_cmd                        i_cmd,
    input  logic [fke_pkg::CHAR_W-1:0]           i_char_code,
    input  logic                                 i_out_ready,
    output fke_pkg::t_sts                        o_sts,
    output logic                                 o_out_valid,
    output logic                                 o_kind,
    output logic [fke_pkg::IDX_W-1:0]            o_letter_index,
    output logic [fke_pkg::OUT_CNT_W-1:0]        o_letter_count,
    output logic signed [fke_pkg::EST_W-1:0]     o_estimate_hundredths,
    output logic                                 o_undefined,
    output logic                                 o_last_result
);
    import fke_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam int WC = COUNT_WIDTH + OUT_CNT_W;

    logic [COUNT_WIDTH-1:0] r_hist [LETTERS];
    logic [COUNT_WIDTH-1:0] r_total;
    logic [P_W-1:0]         r_prod;
    logic                   r_acc_en;
    logic [S_W-1:0]         r_sum;
    logic [P_W-1:0]         r_p;
    logic [A_W-1:0]         r_a, r_b, r_mag;
    logic [DIV_W-1:0]       r_c, r_num, r_den;
    logic [REM_W-1:0]       r_rem;
    logic [EST_W-1:0]       r_q;
    logic                   r_neg, r_undef;
    logic                   r_out_vld;

    logic                   is_letter;
    logic [IDX_W-1:0]       char_idx;
    logic [COUNT_WIDTH-1:0] rd_cnt;
    logic [WC-1:0]          wide_cnt;
    logic [OUT_CNT_W-1:0]   sat_cnt;
    logic [REM_W-1:0]       rem_sh;
    logic                   q_bit;
    logic [EST_W-1:0]       q_sh, q_sat, est_val;

    // Byte decode
    assign is_letter = (i_char_code >= CHAR_W'(CHAR_A)) && (i_char_code <= CHAR_W'(CHAR_Z));
    assign char_idx  = IDX_W'(i_char_code - CHAR_W'(CHAR_A));

    // Histogram lanes and letter total, saturating
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.hist_clear) begin
            for (int k = 0; k < LETTERS; k++) begin
                r_hist[k] <= '0;
            end
            r_total <= '0;
        end else if (i_cmd.count_en && is_letter) begin
            for (int k = 0; k < LETTERS; k++) begin
                if (char_idx == IDX_W'(k) && r_hist[k] != CNT_MAX) begin
                    r_hist[k] <= r_hist[k] + 1'b1;
                end
            end
            if (r_total != CNT_MAX) begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    // Report read and output count clamp
    assign rd_cnt   = r_hist[i_cmd.rpt_idx];
    assign wide_cnt = WC'(rd_cnt);
    assign sat_cnt  = (wide_cnt > WC'({OUT_CNT_W{1'b1}})) ? {OUT_CNT_W{1'b1}}
                                                           : wide_cnt[OUT_CNT_W-1:0];

    // n(n-1) per letter, then accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
            r_sum    <= '0;
        end else begin
            r_acc_en <= i_cmd.rpt_load;
            if (i_cmd.hist_clear) begin
                r_sum <= '0;
            end else if (r_acc_en) begin
                r_sum <= r_sum + S_W'(r_prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rpt_load) begin
            r_prod <= P_W'(rd_cnt) * P_W'(rd_cnt - 1'b1);
        end
    end

    // Restoring divider step with sticky quotient clamp
    assign rem_sh = {r_rem[REM_W-2:0], r_num[DIV_W-1]};
    assign q_bit  = (rem_sh >= REM_W'(r_den));
    assign q_sh   = {r_q[EST_W-2:0], q_bit};

    // Estimate arithmetic, one product or add per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_pn) begin
            r_p <= P_W'(r_total) * P_W'(r_total - 1'b1);
        end
        if (i_cmd.calc_a) begin
            r_a <= A_W'(r_sum) * A_W'(SCALE_S);
        end
        if (i_cmd.calc_b) begin
            r_b <= A_W'(r_p) * A_W'(SCALE_P);
        end
        if (i_cmd.calc_c) begin
            r_c <= DIV_W'(r_p) * DIV_W'(SCALE_NUM);
        end
        if (i_cmd.calc_cmp) begin
            r_neg   <= (r_a < r_b);
            r_mag   <= (r_a < r_b) ? (r_b - r_a) : (r_a - r_b);
            r_undef <= (r_total < COUNT_WIDTH'(2)) || (r_a == r_b);
        end
        if (i_cmd.calc_prep) begin
            r_num <= r_c + DIV_W'(r_mag);
            r_den <= {r_mag, 1'b0};
            r_rem <= '0;
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[DIV_W-2:0], 1'b0};
            r_rem <= q_bit ? (rem_sh - REM_W'(r_den)) : rem_sh;
            r_q   <= (q_sh > EST_W'(EST_LIMIT)) ? EST_W'(EST_LIMIT + 1) : q_sh;
        end
    end

    // Final clamp and sign
    assign q_sat   = (r_q > EST_W'(EST_LIMIT)) ? EST_W'(EST_LIMIT) : r_q;
    assign est_val = r_undef ? '0 : (r_neg ? (~q_sat + 1'b1) : q_sat);

    // Output register
    assign o_sts.out_free = !r_out_vld || i_out_ready;
    assign o_sts.undef    = r_undef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.rpt_load || i_cmd.est_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rpt_load) begin
            o_kind                <= KIND_COUNT;
            o_letter_index        <= i_cmd.rpt_idx;
            o_letter_count        <= sat_cnt;
            o_estimate_hundredths <= '0;
            o_undefined           <= 1'b0;
            o_last_result         <= 1'b0;
        end else if (i_cmd.est_load) begin
            o_kind                <= KIND_EST;
            o_letter_index        <= '0;
            o_letter_count        <= '0;
            o_estimate_hundredths <= est_val;
            o_undefined           <= r_undef;
            o_last_result         <= 1'b1;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

### sim/tb.sv
// Self-checking testbench for friedman_key_length_estimator: letter histogram,
// report sequence and Friedman key length estimate, checked against a local predictor.
// Depends on fke_pkg and the estimator RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fke_pkg::*;

    // One expected result of a report
    typedef struct packed {
        logic                    kind;
        logic [IDX_W-1:0]        idx;
        logic [OUT_CNT_W-1:0]    cnt;
        logic signed [EST_W-1:0] est;
        logic                    undef;
        logic                    last_r;
    } result_t;

    // Directed request; typed rows carry the estimate read straight off the formula
    typedef struct packed {
        logic [CHAR_W-1:0]       code;
        logic                    lst;
        logic                    typed;
        logic signed [EST_W-1:0] est;
        logic                    undef;
    } dir_row_t;

    localparam int NUM_DIRECTED = 24;
    localparam logic [63:0] CNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam int RANDOM_ITEMS = 110 - NUM_DIRECTED;

    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        // report right after reset with no letters at all
        '{8'h00, 1'b1, 1'b1, 0, 1'b1},
        // a single letter is too few
        '{8'h41, 1'b1, 1'b1, 0, 1'b1},
        // two equal letters: IC of one, estimate 2.96 -> 3
        '{8'h5A, 1'b0, 1'b0, 0, 1'b0},
        '{8'h5A, 1'b1, 1'b1, 3, 1'b0},
        // neighbors of A..Z and byte extremes are ignored; two distinct letters
        // give a negative denominator, -74.03 -> -74
        '{8'h40, 1'b0, 1'b0, 0, 1'b0},
        '{8'h5B, 1'b0, 1'b0, 0, 1'b0},
        '{8'h61, 1'b0, 1'b0, 0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 0, 1'b0},
        '{8'h41, 1'b0, 1'b0, 0, 1'b0},
        '{8'h42, 1'b1, 1'b1, -74, 1'b0},
        // repeated word, closed by an ignored byte that carries last
        '{8'h4C, 1'b0, 1'b0, 0, 1'b0},
        '{8'h45, 1'b0, 1'b0, 0, 1'b0},
        '{8'h4D, 1'b0, 1'b0, 0, 1'b0},
        '{8'h4F, 1'b0, 1'b0, 0, 1'b0},
        '{8'h4E, 1'b0, 1'b0, 0, 1'b0},
        '{8'h4C, 1'b0, 1'b0, 0, 1'b0},
        '{8'h45, 1'b0, 1'b0, 0, 1'b0},
        '{8'h4D, 1'b0, 1'b0, 0, 1'b0},
        '{8'h4F, 1'b0, 1'b0, 0, 1'b0},
        '{8'h4E, 1'b0, 1'b0, 0, 1'b0},
        '{8'h7F, 1'b1, 1'b0, 0, 1'b0},
        // three of one letter
        '{8'h51, 1'b0, 1'b0, 0, 1'b0},
        '{8'h51, 1'b0, 1'b0, 0, 1'b0},
        '{8'h51, 1'b1, 1'b0, 0, 1'b0}
    };

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [CHAR_W-1:0]          i_char_code;
    logic                       i_last;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic                       o_kind;
    logic [IDX_W-1:0]           o_letter_index;
    logic [OUT_CNT_W-1:0]       o_letter_count;
    logic signed [EST_W-1:0]    o_estimate_hundredths;
    logic                       o_undefined;
    logic                       o_last_result;

    friedman_key_length_estimator dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_char_code           (i_char_code),
        .i_last                (i_last),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_kind                (o_kind),
        .o_letter_index        (o_letter_index),
        .o_letter_count        (o_letter_count),
        .o_estimate_hundredths (o_estimate_hundredths),
        .o_undefined           (o_undefined),
        .o_last_result         (o_last_result)
    );

    // Predictor state: saturating histogram and letter total
    logic [63:0] hist [LETTERS];
    logic [63:0] letter_sum;
    result_t     pending_results [$];
    int          mismatch_count = 0;
    int          burst_left = 0;
    logic [5:0]  stall_phase = '0;
    logic [15:0] stall_bits = '0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < 100)
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Count one byte; on last, queue the 26 letter counts and the estimate
    function automatic void tally_byte(input logic [CHAR_W-1:0] code, input logic lst);
        logic [63:0] s_sum, pn, a_term, b_term, mag, quot;
        logic signed [EST_W-1:0] est_mag;
        logic neg;
        result_t r;
        int k;
        if (code >= CHAR_A && code <= CHAR_Z) begin
            k = int'(code) - CHAR_A;
            if (hist[k] < CNT_MAX) hist[k] = hist[k] + 64'd1;
            if (letter_sum < CNT_MAX) letter_sum = letter_sum + 64'd1;
        end
        if (!lst) return;

        s_sum = '0;
        for (k = 0; k < LETTERS; k++) begin
            r = '0;
            r.kind = KIND_COUNT;
            r.idx = IDX_W'(k);
            r.cnt = (hist[k] > 64'hFFFF) ? 16'hFFFF : hist[k][OUT_CNT_W-1:0];
            pending_results.push_back(r);
            if (hist[k] != 0) s_sum = s_sum + hist[k] * (hist[k] - 64'd1);
        end

        r = '0;
        r.kind = KIND_EST;
        r.last_r = 1'b1;
        if (letter_sum < 64'd2) begin
            r.undef = 1'b1;
        end else begin
            pn = letter_sum * (letter_sum - 64'd1);
            a_term = s_sum * SCALE_S;
            b_term = pn * SCALE_P;
            if (a_term == b_term) begin
                r.undef = 1'b1;
            end else begin
                // round half away from zero on the magnitude, then saturate
                neg = a_term < b_term;
                mag = neg ? b_term - a_term : a_term - b_term;
                quot = (pn * SCALE_NUM + mag) / (mag * 64'd2);
                if (quot > EST_LIMIT) quot = EST_LIMIT;
                est_mag = quot[EST_W-1:0];
                r.est = neg ? -est_mag : est_mag;
            end
        end
        pending_results.push_back(r);

        foreach (hist[i]) hist[i] = '0;
        letter_sum = '0;
    endfunction

    // Drive one request in bursts with random gaps, wait for acceptance
    task automatic send_byte(input logic [CHAR_W-1:0] code, input logic lst);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            burst_left = $urandom_range(1, 16);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_char_code <= code;
        i_last      <= lst;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tally_byte(code, lst);
    endtask

    // Message of random length over a random-size alphabet, some stray bytes
    task automatic send_random_message(inout int items);
        int len, alphabet, j;
        logic [CHAR_W-1:0] b;
        len = $urandom_range(1, 20);
        alphabet = $urandom_range(1, LETTERS);
        for (j = 0; j < len; j++) begin
            if ($urandom_range(0, 3) == 0) b = CHAR_W'($urandom_range(0, 255));
            else b = CHAR_W'(CHAR_A + $urandom_range(0, alphabet - 1));
            send_byte(b, j == len - 1);
        end
        items += len;
    endtask

    // Stimulus
    initial begin
        int items;
        foreach (hist[i]) hist[i] = '0;
        letter_sum = '0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_char_code <= '0;
        i_last      <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows; typed rows replace the predicted estimate fields
        foreach (DIRECTED[i]) begin
            send_byte(DIRECTED[i].code, DIRECTED[i].lst);
            if (DIRECTED[i].typed) begin
                pending_results[pending_results.size() - 1].est = DIRECTED[i].est;
                pending_results[pending_results.size() - 1].undef = DIRECTED[i].undef;
            end
        end

        // random messages
        items = 0;
        while (items < RANDOM_ITEMS) send_random_message(items);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Receiver: stall pattern refreshed whenever the phase counter wraps, often stall-free;
    // compare each accepted result with the oldest pending one
    always @(posedge i_clk) begin : drain_results
        result_t want;
        stall_phase <= stall_phase + 6'd1;
        if (stall_phase == '0)
            stall_bits <= ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
        i_out_ready <= ~stall_bits[stall_phase[3:0]];

        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending, kind", o_kind, -1);
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind)
                    report_mismatch("kind", o_kind, want.kind);
                if (o_letter_index !== want.idx)
                    report_mismatch("letter_index", o_letter_index, want.idx);
                if (o_letter_count !== want.cnt)
                    report_mismatch("letter_count", o_letter_count, want.cnt);
                if (o_estimate_hundredths !== want.est)
                    report_mismatch("estimate_hundredths", o_estimate_hundredths, want.est);
                if (o_undefined !== want.undef)
                    report_mismatch("undefined", o_undefined, want.undef);
                if (o_last_result !== want.last_r)
                    report_mismatch("last_result", o_last_result, want.last_r);
            end
        end
    end

endmodule
